/* src/ghe_pkg.sv */
// Shared types, constants and GF(2^128) helpers of the GHASH engine.
// Used by every module of the block; depends on nothing else.
package ghe_pkg;

	localparam int CountWidthDef = 61;
	localparam int GfWidth       = 128;
	localparam int HalfWidth     = 64;
	localparam int BlockBytes    = 16;
	localparam int NumPow        = GfWidth;
	localparam int StepsPerPass  = 8;
	localparam int NumPasses     = NumPow / StepsPerPass;
	localparam int PassIdxW      = $clog2(NumPasses);
	localparam int QDepth        = 2;
	localparam int CfgIdxW       = 1;

	localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 1'd1;

	localparam logic [1:0] ACT_AAD    = 2'd0;
	localparam logic [1:0] ACT_TEXT   = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	localparam logic [7:0] GF_REDUCE = 8'hE1;

	typedef logic [GfWidth-1:0] gf_t;
	typedef gf_t [NumPow-1:0] pow_table_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic [4:0]  valid_bytes;
	} item_t;

	typedef struct packed {
		logic [63:0] digest_high;
		logic [63:0] digest_low;
	} result_t;

	typedef enum logic [1:0] {
		KIND_AAD    = 2'd0,
		KIND_TEXT   = 2'd1,
		KIND_FINISH = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		gf_t        data;
		logic [4:0] nbytes;
	} entry_t;

	// Multiply by x in GCM bit order: right shift, fold the dropped bit back in.
	function automatic gf_t gf_shr(input gf_t v);
		gf_t r;
		r = v >> 1;
		if (v[0]) begin
			r[GfWidth-1 -: 8] = r[GfWidth-1 -: 8] ^ GF_REDUCE;
		end
		return r;
	endfunction

	// Keep the first n bytes of a block, byte 0 in the top bits.
	function automatic gf_t byte_mask(input logic [4:0] n);
		gf_t m;
		m = '0;
		for (int b = 0; b < BlockBytes; b++) begin
			if (5'(b) < n) begin
				m[GfWidth-1-8*b -: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

/* src/ghe_key_table.sv */
// Hash subkey registers and the table of H * x^i powers used by the multiplier.
// Depends on ghe_pkg; rebuilt by a sweep after reset and each key write.
module ghe_key_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr,
	input  logic [ghe_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [63:0]                   cfg_data,
	output logic                          table_ready,
	output ghe_pkg::pow_table_t           pow_table
);
	import ghe_pkg::*;

	logic [63:0]          key_high_q;
	logic [63:0]          key_low_q;
	gf_t                  sweep_v_q;
	logic [PassIdxW-1:0]  pass_q;
	logic                 busy_q;
	pow_table_t           pow_q;
	gf_t                  step_p [StepsPerPass];
	logic                 key_hit;
	gf_t                  new_key;

	always_comb begin
		step_p[0] = sweep_v_q;
		for (int j = 1; j < StepsPerPass; j++) begin
			step_p[j] = gf_shr(step_p[j-1]);
		end
	end

	always_comb begin
		key_hit = 1'b0;
		new_key = {key_high_q, key_low_q};
		unique case (cfg_index)
			REG_KEY_HIGH: begin
				key_hit = cfg_wr;
				new_key = {cfg_data, key_low_q};
			end
			REG_KEY_LOW: begin
				key_hit = cfg_wr;
				new_key = {key_high_q, cfg_data};
			end
			default: begin
				key_hit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			sweep_v_q  <= '0;
			pass_q     <= '0;
			busy_q     <= 1'b1;
		end else if (key_hit) begin
			key_high_q <= new_key[GfWidth-1 -: HalfWidth];
			key_low_q  <= new_key[HalfWidth-1:0];
			sweep_v_q  <= new_key;
			pass_q     <= '0;
			busy_q     <= 1'b1;
		end else if (busy_q) begin
			sweep_v_q <= gf_shr(step_p[StepsPerPass-1]);
			pass_q    <= pass_q + 1'b1;
			if (pass_q == PassIdxW'(NumPasses-1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NumPasses; k++) begin
			for (int j = 0; j < StepsPerPass; j++) begin
				if (busy_q && !key_hit && pass_q == PassIdxW'(k)) begin
					pow_q[k*StepsPerPass+j] <= step_p[j];
				end
			end
		end
	end

	assign table_ready = !busy_q;
	assign pow_table   = pow_q;

endmodule

/* src/ghe_front.sv */
// Front end: accepts input items, drops no-ops and builds padded queue entries.
// Depends on ghe_pkg.
module ghe_front (
	input  logic            item_valid,
	output logic            item_ready,
	input  ghe_pkg::item_t  item,
	input  logic            q_space,
	input  logic            table_ready,
	output logic            push,
	output ghe_pkg::entry_t push_entry
);
	import ghe_pkg::*;

	logic [4:0] n_clamp;
	logic       keep;

	assign n_clamp    = (item.valid_bytes > 5'(BlockBytes)) ? 5'(BlockBytes) : item.valid_bytes;
	assign item_ready = q_space && table_ready;

	always_comb begin
		keep              = 1'b0;
		push_entry.kind   = KIND_AAD;
		push_entry.data   = {item.block_high, item.block_low} & byte_mask(n_clamp);
		push_entry.nbytes = n_clamp;
		unique case (item.action)
			ACT_AAD: begin
				keep            = (item.valid_bytes != 5'd0);
				push_entry.kind = KIND_AAD;
			end
			ACT_TEXT: begin
				keep            = (item.valid_bytes != 5'd0);
				push_entry.kind = KIND_TEXT;
			end
			ACT_FINISH: begin
				keep            = 1'b1;
				push_entry.kind = KIND_FINISH;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = item_valid && item_ready && keep;

endmodule

/* src/ghe_queue.sv */
// Short FIFO that decouples the front end from the hashing back end.
// Depends on ghe_pkg.
module ghe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ghe_pkg::entry_t push_entry,
	output logic            space,
	input  logic            pop,
	output logic            head_valid,
	output ghe_pkg::entry_t head
);
	import ghe_pkg::*;

	localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int CntW = $clog2(QDepth + 1);

	entry_t            mem_q [QDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign space      = (count_q < CntW'(QDepth));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

/* src/ghe_back.sv */
// Back end: accumulator, GF(2^128) multiply by H, byte counters, result register.
// Depends on ghe_pkg and on the power table from ghe_key_table.
module ghe_back #(
	parameter int COUNT_WIDTH = ghe_pkg::CountWidthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  ghe_pkg::entry_t     head,
	output logic                pop,
	input  ghe_pkg::pow_table_t pow_table,
	output logic                result_valid,
	input  logic                result_ready,
	output ghe_pkg::result_t    result
);
	import ghe_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

	gf_t                     acc_q;
	logic [COUNT_WIDTH-1:0]  aad_cnt_q;
	logic [COUNT_WIDTH-1:0]  text_cnt_q;
	result_t                 res_q;
	logic                    res_valid_q;
	gf_t                     len_block;
	gf_t                     x;
	gf_t                     z;
	logic                    is_finish;
	logic [COUNT_WIDTH:0]    add_src;
	logic [COUNT_WIDTH:0]    add_sum;
	logic [COUNT_WIDTH-1:0]  sat_sum;

	assign is_finish = (head.kind == KIND_FINISH);
	assign pop       = head_valid && (!is_finish || !res_valid_q || result_ready);

	assign len_block = {64'({aad_cnt_q, 3'b000}), 64'({text_cnt_q, 3'b000})};
	assign x         = acc_q ^ (is_finish ? len_block : head.data);

	// Bit i of x in GCM order is x[127-i]; it selects the term H * x^i.
	always_comb begin
		z = '0;
		for (int i = 0; i < NumPow; i++) begin
			if (x[GfWidth-1-i]) begin
				z = z ^ pow_table[i];
			end
		end
	end

	assign add_src = (head.kind == KIND_AAD) ? {1'b0, aad_cnt_q} : {1'b0, text_cnt_q};
	assign add_sum = add_src + (COUNT_WIDTH+1)'(head.nbytes);
	assign sat_sum = add_sum[COUNT_WIDTH] ? CountMax : add_sum[COUNT_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			aad_cnt_q   <= '0;
			text_cnt_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (head.kind)
					KIND_FINISH: begin
						acc_q       <= '0;
						aad_cnt_q   <= '0;
						text_cnt_q  <= '0;
						res_valid_q <= 1'b1;
					end
					KIND_AAD: begin
						acc_q     <= z;
						aad_cnt_q <= sat_sum;
					end
					KIND_TEXT: begin
						acc_q      <= z;
						text_cnt_q <= sat_sum;
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_finish) begin
			res_q.digest_high <= z[GfWidth-1 -: HalfWidth];
			res_q.digest_low  <= z[HalfWidth-1:0];
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

/* src/gcm_ghash_engine_unit.sv */
// GHASH engine top level. Throughput: one block or finish transaction per cycle while the key table is
// ready and no finish waits on a full result register. A finish passes the queue, then the result register.
// The front end feeds a two-entry queue; the back end does one full GF(2^128) multiply per cycle.
// Reset (arst_n, asynchronous, active low) clears key, accumulator, counters and the queue,
// then a sweep builds the key power table; every key write repeats that sweep.
module gcm_ghash_engine_unit #(
	parameter int COUNT_WIDTH = ghe_pkg::CountWidthDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  ghe_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output ghe_pkg::result_t            result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ghe_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [63:0]                 cfg_data
);
	import ghe_pkg::*;

	// Key table: configuration is always accepted. A write to a key half restarts
	// the power sweep, and input transactions are held off until it is done.
	logic       table_ready;
	pow_table_t pow_table;

	assign cfg_ready = 1'b1;

	ghe_key_table u_key_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.table_ready (table_ready),
		.pow_table   (pow_table)
	);

	// Front end: masks the block past its valid bytes, clamps the byte count and
	// discards transactions that do nothing (unused action, empty absorb).
	logic   q_space;
	logic   push;
	entry_t push_entry;

	ghe_front u_front (
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.q_space     (q_space),
		.table_ready (table_ready),
		.push        (push),
		.push_entry  (push_entry)
	);

	// Queue: lets a finish wait on a full result register while new blocks arrive.
	logic   q_head_valid;
	entry_t q_head;
	logic   pop;

	ghe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.space      (q_space),
		.pop        (pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// Back end: XOR into the accumulator and multiply by H in the same cycle. A
	// finish folds in the bit lengths, loads the result register and clears state.
	ghe_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_head_valid),
		.head         (q_head),
		.pop          (pop),
		.pow_table    (pow_table),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// A key write must hold off input while the power table is rebuilt.
	a_key_write_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW))
		|=> !item_ready)
		else $error("input taken right after a key write");

	// An accepted finish transaction must leave the queue non-empty in the following cycle.
	a_finish_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.action == ACT_FINISH) |=> q_head_valid)
		else $error("finish transaction lost between front and back end");

	// The back end never consumes from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_head_valid)
		else $error("pop from empty queue");

endmodule
